// ----- hdl/beat_interval_tempo_estimator_unit_defines.svh -----
// Assertion helpers shared by the checker.
`ifndef BEAT_INTERVAL_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH
`define BEAT_INTERVAL_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH

// Checked outside reset only.
`define BITE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define BITE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/bite_pkg.sv -----
package bite_pkg;

  localparam int unsigned IV_W      = 12;
  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned TEMPO_W   = 16;
  localparam int unsigned CLS_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned WINDOW_DEF = 8;

  localparam int unsigned BPM_W = 24;
  localparam logic [BPM_W-1:0] BPM_NUM_Q8 = 24'd15360000;

  localparam logic [IV_W-1:0] TICK_MAX    = 12'd4095;
  localparam logic [IV_W-1:0] MIN_IV_RST  = 12'd272;
  localparam logic [IV_W-1:0] MAX_IV_RST  = 12'd2500;

  localparam int unsigned DIV_DEN_W = IV_W;

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // class codes
  localparam logic [CLS_W-1:0] CLS_BEAT     = 2'd0;
  localparam logic [CLS_W-1:0] CLS_DOWNBEAT = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NONE     = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IV = 2'd1;

  typedef struct packed {
    logic               operation;
    logic [SCORE_W-1:0] score_beat;
    logic [SCORE_W-1:0] score_downbeat;
    logic [SCORE_W-1:0] score_none;
  } in_item_t;

  typedef struct packed {
    logic [CLS_W-1:0]   winning_class;
    logic               tempo_updated;
    logic [TEMPO_W-1:0] tempo_q8;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/bite_div.sv -----
// Restoring divider, one quotient bit per cycle. Quotient shifts into the
// dividend register as the dividend bits shift out.
module bite_div #(
  parameter int unsigned NUM_W = bite_pkg::BPM_W,
  parameter int unsigned DEN_W = bite_pkg::DIV_DEN_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]    den_i,
  output logic [NUM_W-1:0]    quo_o,
  output bite_pkg::div_stat_t stat_o
);
  import bite_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             qbit;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign qbit    = ~diff[DEN_W+1];

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      num_d  = {num_q[NUM_W-2:0], qbit};
      rem_d  = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o       = num_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

// ----- hdl/beat_interval_tempo_estimator_unit.sv -----
// Tick item: no result. Class-none frame or rejected beat: passes through ST_DONE
// into the output register; the next item is taken once the state is back in idle.
// Accepted beat: ST_BPM, ST_SMEAN, ST_MEAN, ST_DONE, then output register; the
// bit-serial divider (24 steps) runs twice, bpm then mean. Input ready only in
// idle; a finished result waits in the output register while ticks flow. Async
// active-low reset returns counter, tempo, sum, fill, slot and config to defaults; RAM kept.
module beat_interval_tempo_estimator_unit #(
  parameter int unsigned WINDOW = bite_pkg::WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bite_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bite_pkg::IV_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bite_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output bite_pkg::out_item_t                out_item_o
);
  import bite_pkg::*;

  // window geometry
  localparam int unsigned SUM_W  = TEMPO_W + $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NUM_W  = (SUM_W > BPM_W) ? SUM_W : BPM_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,  // waiting for an item
    ST_BPM   = 5'b00010,  // dividing constant by interval
    ST_SMEAN = 5'b00100,  // window updated, kick off mean division
    ST_MEAN  = 5'b01000,  // dividing sum by fill count
    ST_DONE  = 5'b10000   // result ready to load into output register
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [IV_W-1:0] min_iv_q, max_iv_q;

  // tempo tracking state
  logic [IV_W-1:0]    elapsed_q, elapsed_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [TEMPO_W-1:0] tempo_q, tempo_d;

  // window RAM, read port registered
  logic [TEMPO_W-1:0] win_mem [WINDOW];
  logic [TEMPO_W-1:0] old_q;
  logic               win_we;
  logic [TEMPO_W-1:0] bpm;

  // result under construction
  logic [CLS_W-1:0] cls_q, cls_d;
  logic             upd_q, upd_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      out_load;

  // divider hookup
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  div_stat_t        div_stat;

  // frame decode
  logic             in_acc;
  logic [CLS_W-1:0] cls_pick;
  logic             iv_ok;
  logic             win_full;

  bite_div #(
    .NUM_W (NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // first maximum wins, ties go to the lower class
  always_comb begin
    logic [SCORE_W-1:0] best;
    cls_pick = CLS_BEAT;
    best     = in_item_i.score_beat;
    if (in_item_i.score_downbeat > best) begin
      cls_pick = CLS_DOWNBEAT;
      best     = in_item_i.score_downbeat;
    end
    if (in_item_i.score_none > best) begin
      cls_pick = CLS_NONE;
    end
  end

  // zero interval always rejected; crossed bounds reject everything
  assign iv_ok = (elapsed_q != '0) && (elapsed_q >= min_iv_q) && (elapsed_q <= max_iv_q);

  // bpm saturates at full scale for short intervals
  assign bpm = (div_quo[NUM_W-1:TEMPO_W] != '0) ? {TEMPO_W{1'b1}} : div_quo[TEMPO_W-1:0];

  assign win_full = (fill_q == FILL_W'(WINDOW));
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    tempo_d     = tempo_q;
    cls_d       = cls_q;
    upd_d       = upd_q;
    win_we      = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.operation == OP_TICK) begin
            if (elapsed_q != TICK_MAX) begin
              elapsed_d = elapsed_q + IV_W'(1);
            end
          end else begin
            cls_d   = cls_pick;
            upd_d   = 1'b0;
            state_d = ST_DONE;
            if (cls_pick != CLS_NONE) begin
              elapsed_d = '0;
              if (iv_ok) begin
                upd_d     = 1'b1;
                div_start = 1'b1;
                div_num   = NUM_W'(BPM_NUM_Q8);
                div_den   = elapsed_q;
                state_d   = ST_BPM;
              end
            end
          end
        end
      end
      ST_BPM: begin
        if (div_stat.done) begin
          // oldest entry drops out once the window is full
          win_we = 1'b1;
          if (win_full) begin
            sum_d = sum_q - SUM_W'(old_q) + SUM_W'(bpm);
          end else begin
            sum_d  = sum_q + SUM_W'(bpm);
            fill_d = fill_q + FILL_W'(1);
          end
          if (slot_q == SLOT_W'(WINDOW - 1)) begin
            slot_d = '0;
          end else begin
            slot_d = slot_q + SLOT_W'(1);
          end
          state_d = ST_SMEAN;
        end
      end
      ST_SMEAN: begin
        div_start = 1'b1;
        div_num   = NUM_W'(sum_q);
        div_den   = DIV_DEN_W'(fill_q);
        state_d   = ST_MEAN;
      end
      ST_MEAN: begin
        if (div_stat.done) begin
          tempo_d = div_quo[TEMPO_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_iv_q    <= MIN_IV_RST;
      max_iv_q    <= MAX_IV_RST;
      elapsed_q   <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      tempo_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      tempo_q     <= tempo_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_IV: min_iv_q <= cfg_data_i;
          REG_MAX_IV: max_iv_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    upd_q <= upd_d;
    if (out_load) begin
      out_item_q.winning_class <= cls_q;
      out_item_q.tempo_updated <= upd_q;
      out_item_q.tempo_q8      <= tempo_q;
    end
  end

  // window RAM: slot is stable through the bpm division, so old_q is settled
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[slot_q] <= bpm;
    end
    old_q <= win_mem[slot_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hdl/bite_chk.sv -----
`include "beat_interval_tempo_estimator_unit_defines.svh"

module bite_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bite_pkg::out_item_t out_item_o
);
  import bite_pkg::*;

  `BITE_ASSERT_ALWAYS(a_rst_no_result, !rst_ni |-> !out_valid_o, "result valid during reset")

  `BITE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "stalled result changed")

  `BITE_ASSERT(a_none_no_update, out_valid_o && (out_item_o.winning_class == CLS_NONE) |-> !out_item_o.tempo_updated, "non-beat item updated tempo")

  `BITE_ASSERT(a_update_nonzero, out_valid_o && out_item_o.tempo_updated |-> (out_item_o.tempo_q8 != '0), "updated tempo is zero")

endmodule

bind beat_interval_tempo_estimator_unit bite_chk u_bite_chk (.*);

// ----- dv/tb_beat_interval_tempo_estimator_unit.sv -----
module tb_beat_interval_tempo_estimator_unit;
  import bite_pkg::*;

  localparam int unsigned RING_N      = WINDOW_DEF;
  localparam int unsigned HOLD_CYCLES = 600;      // long sink hold-off
  localparam int unsigned SETTLE_CYC  = 64;       // outlasts an accepted beat
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 10;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    in_item_t item;
    bit       wait_drained;  // hold this item back until no result is owed
  } pending_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT-facing signals (driven ones known from time zero)
  // ---------------------------------------------------------------------------
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b1;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [IV_W-1:0]      cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;

  always #6 clk_i = ~clk_i;

  beat_interval_tempo_estimator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // Tempo tracker: mirror of the block's state, updated on every accepted item
  // ---------------------------------------------------------------------------
  logic [IV_W-1:0]    lim_lo = MIN_IV_RST;
  logic [IV_W-1:0]    lim_hi = MAX_IV_RST;
  logic [IV_W-1:0]    ms_count = '0;
  logic [TEMPO_W-1:0] bpm_ring [RING_N];
  int unsigned        ring_slot = 0;
  int unsigned        ring_fill = 0;
  int unsigned        ring_sum  = 0;
  logic [TEMPO_W-1:0] tempo_now = '0;

  out_item_t   tempo_due_q [$];   // results the block still owes, oldest first
  pending_t    beat_stream_q [$]; // items waiting to be offered

  // Bookkeeping
  int unsigned faults = 0;
  int unsigned ticks_seen = 0, frames_seen = 0, tempo_updates = 0;
  int unsigned sat_hits = 0, ring_wraps = 0, rejects = 0, cfg_writes = 0;
  int unsigned frames_made = 0;
  int unsigned frames_accepted = 0, results_taken = 0;  // NBA-updated
  int unsigned hold_requests = 0;                       // NBA-updated
  bit          calm = 1'b0;                              // no idling when set
  int unsigned cycle_count = 0;

  task automatic flag_fault(input string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Apply one accepted item to the mirror; frames queue their expected result.
  task automatic track_item(input in_item_t it);
    out_item_t          res;
    logic [CLS_W-1:0]   cls;
    logic [SCORE_W-1:0] best;
    int unsigned        bpm;
    res = '0;
    if (it.operation == OP_TICK) begin
      if (ms_count != TICK_MAX) ms_count++;  // saturates at full scale
      ticks_seen++;
    end else begin
      // first maximum wins: ties go to the lower class
      cls  = CLS_BEAT;
      best = it.score_beat;
      if (it.score_downbeat > best) begin
        cls  = CLS_DOWNBEAT;
        best = it.score_downbeat;
      end
      if (it.score_none > best) cls = CLS_NONE;
      res.winning_class = cls;
      res.tempo_updated = 1'b0;
      if (cls != CLS_NONE) begin
        // zero interval never counts, whatever the lower bound says
        if (ms_count != 0 && ms_count >= lim_lo && ms_count <= lim_hi) begin
          bpm = BPM_NUM_Q8 / ms_count;
          if (bpm > 32'hFFFF) begin
            bpm = 32'hFFFF;
            sat_hits++;
          end
          if (ring_fill >= RING_N) begin
            ring_sum -= bpm_ring[ring_slot];  // drop the oldest entry
            ring_wraps++;
          end else begin
            ring_fill++;
          end
          bpm_ring[ring_slot] = bpm[TEMPO_W-1:0];
          ring_sum += bpm;
          ring_slot = (ring_slot + 1) % RING_N;
          tempo_now = TEMPO_W'(ring_sum / ring_fill);
          res.tempo_updated = 1'b1;
          tempo_updates++;
        end else begin
          rejects++;
        end
        ms_count = '0;
      end
      res.tempo_q8 = tempo_now;
      tempo_due_q.insert(tempo_due_q.size(), res);
      frames_seen++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, random idle bursts, honors drain markers
  // ---------------------------------------------------------------------------
  pending_t    drv_cur;
  int unsigned send_gap = 0;

  always @(posedge clk_i) begin
    logic        next_valid;
    bit          took_frame;
    int unsigned owed;
    next_valid = in_valid_i;
    took_frame = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_item(drv_cur.item);
        took_frame = (drv_cur.item.operation == OP_FRAME);
        if (took_frame) frames_accepted <= frames_accepted + 1;
        next_valid = 1'b0;
      end
      // results still owed, counting a frame taken at this very edge
      owed = frames_accepted - results_taken + (took_frame ? 1 : 0);
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (beat_stream_q.size() > 0 &&
                     !(beat_stream_q[0].wait_drained && owed != 0)) begin
          if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 18) - 1;
          end else begin
            drv_cur    = beat_stream_q.pop_front();
            in_item_i <= drv_cur.item;
            next_valid = 1'b1;
          end
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest expectation; random stalls
  // plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;

  always @(posedge clk_i) begin
    logic      next_ready;
    out_item_t want;
    next_ready = out_ready_i;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_taken <= results_taken + 1;
        if (tempo_due_q.size() == 0) begin
          flag_fault($sformatf("unexpected result cls=%0d upd=%0d tempo=%h",
                               out_item_o.winning_class, out_item_o.tempo_updated,
                               out_item_o.tempo_q8));
        end else begin
          want = tempo_due_q.pop_front();
          if (out_item_o.winning_class !== want.winning_class ||
              out_item_o.tempo_updated !== want.tempo_updated ||
              out_item_o.tempo_q8      !== want.tempo_q8) begin
            flag_fault($sformatf({"result %0d: exp cls=%0d upd=%0d tempo=%h, ",
                                  "got cls=%0d upd=%0d tempo=%h"},
                                 results_taken, want.winning_class, want.tempo_updated,
                                 want.tempo_q8, out_item_o.winning_class,
                                 out_item_o.tempo_updated, out_item_o.tempo_q8));
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
    end
    out_ready_i <= next_ready;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [IV_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    // block is idle here, so the mirror can follow at once
    if (idx == REG_MIN_IV) lim_lo = val;
    else if (idx == REG_MAX_IV) lim_hi = val;
    cfg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(input in_item_t it, input bit wait_drained);
    pending_t p;
    p.item         = it;
    p.wait_drained = wait_drained;
    beat_stream_q.insert(beat_stream_q.size(), p);
    if (it.operation == OP_FRAME) frames_made++;
  endtask

  function automatic in_item_t mk_item(input logic op, input logic [SCORE_W-1:0] b,
                                       input logic [SCORE_W-1:0] d,
                                       input logic [SCORE_W-1:0] n);
    in_item_t it;
    it.operation      = op;
    it.score_beat     = b;
    it.score_downbeat = d;
    it.score_none     = n;
    return it;
  endfunction

  function automatic in_item_t rand_item(input logic op);
    return mk_item(op, SCORE_W'($urandom_range(0, 65535)),
                   SCORE_W'($urandom_range(0, 65535)),
                   SCORE_W'($urandom_range(0, 65535)));
  endfunction

  // Frame whose argmax is the given class, with ties now and then.
  function automatic in_item_t make_frame(input logic [CLS_W-1:0] win);
    in_item_t           it;
    logic [SCORE_W-1:0] top;
    bit                 tie;
    top = SCORE_W'($urandom_range(1, 65535));
    tie = ($urandom_range(0, 5) == 0);
    it.operation = OP_FRAME;
    case (win)
      CLS_BEAT: begin
        it.score_beat     = top;
        it.score_downbeat = tie ? top : SCORE_W'($urandom_range(0, top));
        it.score_none     = tie ? top : SCORE_W'($urandom_range(0, top));
      end
      CLS_DOWNBEAT: begin
        it.score_downbeat = top;
        it.score_beat     = SCORE_W'($urandom_range(0, top - 1));
        it.score_none     = tie ? top : SCORE_W'($urandom_range(0, top));
      end
      default: begin
        it.score_none     = top;
        it.score_beat     = SCORE_W'($urandom_range(0, top - 1));
        it.score_downbeat = SCORE_W'($urandom_range(0, top - 1));
      end
    endcase
    return it;
  endfunction

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_item(rand_item(OP_TICK), 1'b0);
  endtask

  // Mostly well-formed beat sequences (a run of ticks, then a beat or downbeat),
  // with stray none frames and random noise items mixed in.
  task automatic random_phase(input int unsigned budget, input bit use_drain);
    int unsigned made, gap, lo, hi, r, lo_cfg, hi_cfg;
    bit          drain;
    made   = 0;
    lo_cfg = lim_lo;
    hi_cfg = lim_hi;
    while (made < budget) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        push_item(rand_item(1'($urandom_range(0, 1))), 1'b0);
        made++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65 && lo_cfg <= hi_cfg) begin
          lo = lo_cfg;
          hi = (hi_cfg > lo_cfg + 90) ? lo_cfg + 90 : hi_cfg;
        end else if (r < 85) begin
          lo = 0;
          hi = 4;
        end else begin
          lo = 0;
          hi = (hi_cfg > 440) ? 450 : hi_cfg + 10;
        end
        gap = $urandom_range(lo, hi);
        if ($urandom_range(0, 4) == 0) begin
          push_item(make_frame(CLS_NONE), 1'b0);  // leaves the counter running
          made++;
        end
        push_ticks(gap);
        drain = use_drain && ($urandom_range(0, 7) == 0);
        push_item(make_frame($urandom_range(0, 1) ? CLS_BEAT : CLS_DOWNBEAT), drain);
        made += gap + 1;
      end
    end
  endtask

  // Wait until every item went in and every owed result came out, then let
  // any tick still in flight finish. Sampled on the falling edge.
  task automatic settle();
    while (beat_stream_q.size() != 0 || in_valid_i || frames_accepted != results_taken)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned lo_pick, hi_pick;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset bounds: argmax corner cases, zero interval, short interval.
    push_item(mk_item(OP_FRAME, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    push_item(mk_item(OP_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    push_item(mk_item(OP_FRAME, 16'h0000, 16'hFFFF, 16'hFFFF), 1'b0);
    push_item(mk_item(OP_FRAME, 16'h8000, 16'h7FFF, 16'h8001), 1'b0);
    push_item(mk_item(OP_FRAME, 16'h1234, 16'h1234, 16'h0000), 1'b0);
    push_item(mk_item(OP_FRAME, 16'h0000, 16'h0000, 16'h0001), 1'b0);
    push_ticks(3);
    push_item(mk_item(OP_FRAME, 16'h0000, 16'h0001, 16'h0000), 1'b0);
    settle();

    // Widest bounds; spare indexes must be ignored. Tiny intervals saturate bpm.
    cfg_write(REG_MIN_IV, 12'd1);
    cfg_write(REG_MAX_IV, 12'd4095);
    cfg_write(REG_SPARE_2, 12'd0);
    cfg_write(REG_SPARE_3, 12'hFFF);
    push_ticks(3);
    push_item(make_frame(CLS_BEAT), 1'b0);
    push_ticks(1);
    push_item(make_frame(CLS_DOWNBEAT), 1'b0);
    push_item(make_frame(CLS_BEAT), 1'b0);
    settle();

    // Lower bound of zero still rejects a zero interval.
    cfg_write(REG_MIN_IV, 12'd0);
    cfg_write(REG_MAX_IV, 12'd0);
    push_item(make_frame(CLS_BEAT), 1'b0);
    push_ticks(1);
    push_item(make_frame(CLS_DOWNBEAT), 1'b0);
    settle();

    // Crossed bounds reject everything.
    cfg_write(REG_MIN_IV, 12'd5);
    cfg_write(REG_MAX_IV, 12'd3);
    push_ticks(4);
    push_item(make_frame(CLS_BEAT), 1'b0);
    settle();

    // Random part: a different bound setting per phase.
    cfg_write(REG_MIN_IV, 12'd1);
    cfg_write(REG_MAX_IV, 12'd4095);
    random_phase(300, 1'b1);
    settle();

    // Realistic tempo range; sink holds off while the source keeps pushing.
    cfg_write(REG_MIN_IV, 12'd240);
    cfg_write(REG_MAX_IV, 12'd320);
    @(posedge clk_i);
    hold_requests <= hold_requests + 1;
    random_phase(450, 1'b0);
    settle();

    cfg_write(REG_MIN_IV, 12'd0);
    cfg_write(REG_MAX_IV, 12'd30);
    random_phase(200, 1'b1);
    settle();

    lo_pick = $urandom_range(1, 120);
    hi_pick = $urandom_range(lo_pick, 350);
    cfg_write(REG_MIN_IV, lo_pick[IV_W-1:0]);
    cfg_write(REG_MAX_IV, hi_pick[IV_W-1:0]);
    random_phase(250, 1'b1);
    settle();

    cfg_write(REG_MIN_IV, 12'd20);
    cfg_write(REG_MAX_IV, 12'd10);
    random_phase(150, 1'b0);
    settle();

    // Final stretch at full throughput.
    @(posedge clk_i);
    calm <= 1'b1;
    cfg_write(REG_MIN_IV, 12'd200);
    cfg_write(REG_MAX_IV, 12'd380);
    random_phase(300, 1'b0);
    while (frames_made < 80) random_phase(40, 1'b0);
    settle();

    if (tempo_due_q.size() != 0)
      flag_fault($sformatf("%0d results never arrived", tempo_due_q.size()));

    $display("Covered %0d ticks and %0d frames over %0d register writes.",
             ticks_seen, frames_seen, cfg_writes);
    $display("Tempo updated %0d times (%0d saturated, %0d window wraps), %0d beats rejected.",
             tempo_updates, sat_hits, ring_wraps, rejects);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", faults);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bite_pkg.sv
hdl/bite_div.sv
hdl/beat_interval_tempo_estimator_unit.sv
hdl/bite_chk.sv
dv/tb_beat_interval_tempo_estimator_unit.sv
